// File: hdl/rmq_pkg.sv
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

endpackage

// File: hdl/rmq_in_if.sv
interface rmq_in_if #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] m00;
  logic signed [DATA_WIDTH-1:0] m01;
  logic signed [DATA_WIDTH-1:0] m02;
  logic signed [DATA_WIDTH-1:0] m10;
  logic signed [DATA_WIDTH-1:0] m11;
  logic signed [DATA_WIDTH-1:0] m12;
  logic signed [DATA_WIDTH-1:0] m20;
  logic signed [DATA_WIDTH-1:0] m21;
  logic signed [DATA_WIDTH-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// File: hdl/rmq_out_if.sv
interface rmq_out_if #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic [1:0]                   branch_used;
  logic                         degenerate;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_used, degenerate,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, branch_used, degenerate,
                  output ready);
endinterface

// File: hdl/rotation_matrix_to_quaternion.sv
// channel   dir   modport  payload
// in_ch     in    sink     m00..m22, signed DATA_WIDTH each
// out_ch    out   source   quat_x/y/z/w, branch_used, degenerate
//
// one beat per cycle in and out while out_ch.ready holds high
// stages: 1 front stage, sqrt stages (one root bit each), 1 dividend setup stage, DATA_WIDTH-1
//   divide stages (one quotient bit each, four lanes), 1 output stage
// reset clears only the valid bits of the stages
// a stall at the output freezes the whole pipeline; in_ch.ready follows it
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = (W > F) ? W : F;
  localparam int RADW = MW + 3;
  localparam int VW0  = RADW - 1 + F;
  localparam int RB   = (VW0 + 1) / 2;
  localparam int VW   = 2 * RB;
  localparam int NUMW = W + 1;
  localparam int NW0  = NUMW + F;
  localparam int NW   = ((NW0 > RB) ? NW0 : RB) + 1;
  localparam int QB   = W - 1;
  localparam int CW0  = RB + 1 + QB;
  localparam int CW   = ((NW > CW0) ? NW : CW0) + 1;

  localparam logic [W-1:0] DMAX    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] DMIN    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_SAT = (F >= W - 1) ? DMAX : (W'(1) << F);

  typedef struct packed {
    logic                 vld;
    logic [1:0]           branch;
    logic                 degen;
    logic [VW-1:0]        v;
    logic [RB+1:0]        rem;
    logic [RB-1:0]        root;
    logic [3:0][NUMW-1:0] mag;
    logic [3:0]           neg;
  } sq_stage_t;

  typedef struct packed {
    logic               vld;
    logic [1:0]         branch;
    logic               degen;
    logic [RB-1:0]      root;
    logic [3:0][CW-1:0] rem;
    logic [3:0][QB-1:0] quo;
    logic [3:0]         ovf;
    logic [3:0]         neg;
  } dv_stage_t;

  typedef struct packed {
    logic               vld;
    logic [3:0][W-1:0]  q;
    logic [1:0]         branch;
    logic               degen;
  } out_stage_t;

  logic       en;
  out_stage_t out_r, out_nxt;
  sq_stage_t  sq_r  [RB+1];
  sq_stage_t  sq_nxt[RB+1];
  dv_stage_t  dv_r  [QB+1];
  dv_stage_t  dv_nxt[QB+1];

  assign en          = ~out_r.vld | out_ch.ready;
  assign in_ch.ready = en;

  // front: trace, branch choice, radicand, numerators
  logic signed [RADW-1:0] e00, e11, e22, tr, rad, one_fx;
  logic signed [NUMW-1:0] s01, d01, s02, d20, s12, d12;
  logic signed [3:0][NUMW-1:0] num;
  logic [1:0] br;

  always_comb begin
    e00    = $signed({{(RADW-W){in_ch.m00[W-1]}}, in_ch.m00});
    e11    = $signed({{(RADW-W){in_ch.m11[W-1]}}, in_ch.m11});
    e22    = $signed({{(RADW-W){in_ch.m22[W-1]}}, in_ch.m22});
    one_fx = $signed(RADW'(1) << F);
    tr     = e00 + e11 + e22;
    s01 = $signed({in_ch.m01[W-1], in_ch.m01}) + $signed({in_ch.m10[W-1], in_ch.m10});
    d01 = $signed({in_ch.m01[W-1], in_ch.m01}) - $signed({in_ch.m10[W-1], in_ch.m10});
    s02 = $signed({in_ch.m20[W-1], in_ch.m20}) + $signed({in_ch.m02[W-1], in_ch.m02});
    d20 = $signed({in_ch.m20[W-1], in_ch.m20}) - $signed({in_ch.m02[W-1], in_ch.m02});
    s12 = $signed({in_ch.m12[W-1], in_ch.m12}) + $signed({in_ch.m21[W-1], in_ch.m21});
    d12 = $signed({in_ch.m12[W-1], in_ch.m12}) - $signed({in_ch.m21[W-1], in_ch.m21});
    priority if (tr > 0) begin
      br  = rmq_pkg::BR_TRACE;
      rad = tr + one_fx;
    end else if (in_ch.m00 > in_ch.m11 && in_ch.m00 > in_ch.m22) begin
      br  = rmq_pkg::BR_X;
      rad = one_fx + e00 - e11 - e22;
    end else if (in_ch.m11 > in_ch.m22) begin
      br  = rmq_pkg::BR_Y;
      rad = one_fx + e11 - e00 - e22;
    end else begin
      br  = rmq_pkg::BR_Z;
      rad = one_fx + e22 - e00 - e11;
    end
    num = '0;
    unique case (br)
      rmq_pkg::BR_TRACE: begin
        num[0] = d12; num[1] = d20; num[2] = d01;
      end
      rmq_pkg::BR_X: begin
        num[1] = s01; num[2] = s02; num[3] = d12;
      end
      rmq_pkg::BR_Y: begin
        num[0] = s01; num[2] = s12; num[3] = d20;
      end
      default: begin
        num[0] = s02; num[1] = s12; num[3] = d01;
      end
    endcase
    sq_nxt[0]        = '0;
    sq_nxt[0].vld    = in_ch.valid;
    sq_nxt[0].branch = br;
    sq_nxt[0].degen  = (rad <= 0);
    sq_nxt[0].v      = (rad > 0) ? (VW'(unsigned'(rad[RADW-2:0])) << F) : '0;
    for (int l = 0; l < 4; l++) begin
      sq_nxt[0].neg[l] = num[l][NUMW-1];
      sq_nxt[0].mag[l] = num[l][NUMW-1] ? NUMW'(-num[l]) : NUMW'(num[l]);
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < RB; k++) begin : g_sq
    logic [RB+1:0] r_in, trial;
    always_comb begin
      r_in  = {sq_r[k].rem[RB-1:0], sq_r[k].v[VW-1:VW-2]};
      trial = {sq_r[k].root, 2'b01};
      sq_nxt[k+1]      = sq_r[k];
      sq_nxt[k+1].v    = sq_r[k].v << 2;
      if (r_in >= trial) begin
        sq_nxt[k+1].rem  = r_in - trial;
        sq_nxt[k+1].root = {sq_r[k].root[RB-2:0], 1'b1};
      end else begin
        sq_nxt[k+1].rem  = r_in;
        sq_nxt[k+1].root = {sq_r[k].root[RB-2:0], 1'b0};
      end
    end
  end

  // dividend setup and overflow check
  always_comb begin
    logic [CW-1:0] dd;
    dd = CW'(sq_r[RB].root) << 1;
    dv_nxt[0]        = '0;
    dv_nxt[0].vld    = sq_r[RB].vld;
    dv_nxt[0].branch = sq_r[RB].branch;
    dv_nxt[0].degen  = sq_r[RB].degen;
    dv_nxt[0].root   = sq_r[RB].root;
    dv_nxt[0].neg    = sq_r[RB].neg;
    for (int l = 0; l < 4; l++) begin
      dv_nxt[0].rem[l] = (CW'(sq_r[RB].mag[l]) << F) + CW'(sq_r[RB].root);
      dv_nxt[0].ovf[l] = (dv_nxt[0].rem[l] >= (dd << QB));
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_dv
    logic [CW-1:0] ds;
    always_comb begin
      ds = (CW'(dv_r[j].root) << 1) << (QB - 1 - j);
      dv_nxt[j+1] = dv_r[j];
      for (int l = 0; l < 4; l++) begin
        if (dv_r[j].rem[l] >= ds) begin
          dv_nxt[j+1].rem[l] = dv_r[j].rem[l] - ds;
          dv_nxt[j+1].quo[l] = {dv_r[j].quo[l][QB-2:0], 1'b1};
        end else begin
          dv_nxt[j+1].quo[l] = {dv_r[j].quo[l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturation, diagonal component, degenerate override
  always_comb begin
    logic [1:0]    big_l;
    logic [RB-1:0] big;
    logic [W-1:0]  qz;
    big_l = (dv_r[QB].branch == rmq_pkg::BR_TRACE) ? 2'd3 : (dv_r[QB].branch - 2'd1);
    big   = dv_r[QB].root >> 1;
    out_nxt        = '0;
    out_nxt.vld    = dv_r[QB].vld;
    out_nxt.branch = dv_r[QB].branch;
    out_nxt.degen  = dv_r[QB].degen;
    for (int l = 0; l < 4; l++) begin
      qz = W'(dv_r[QB].quo[l]);
      if (dv_r[QB].degen) begin
        out_nxt.q[l] = (l == 3) ? ONE_SAT : '0;
      end else if (2'(l) == big_l) begin
        out_nxt.q[l] = (CW'(big) > CW'(DMAX)) ? DMAX : W'(big);
      end else if (dv_r[QB].ovf[l]) begin
        out_nxt.q[l] = dv_r[QB].neg[l] ? DMIN : DMAX;
      end else begin
        out_nxt.q[l] = dv_r[QB].neg[l] ? W'(-qz) : qz;
      end
    end
  end

  for (genvar k = 0; k <= RB; k++) begin : g_sq_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k].vld <= 1'b0;
      end else if (en) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
  end

  for (genvar j = 0; j <= QB; j++) begin : g_dv_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j].vld <= 1'b0;
      end else if (en) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_r.vld;
  assign out_ch.quat_x      = out_r.q[0];
  assign out_ch.quat_y      = out_r.q[1];
  assign out_ch.quat_z      = out_r.q[2];
  assign out_ch.quat_w      = out_r.q[3];
  assign out_ch.branch_used = out_r.branch;
  assign out_ch.degenerate  = out_r.degen;

endmodule

// File: test/tb_rotation_matrix_to_quaternion.sv
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = rmq_pkg::DATA_WIDTH_DEF;
  localparam int FB = rmq_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam longint QMAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint QMIN = -(longint'(1) << (DW - 1));
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 200;

  typedef logic signed [DW-1:0] fx_t;
  typedef struct {
    fx_t m[9];
  } matrix_t;
  typedef struct {
    fx_t x, y, z, w;
    logic [1:0] br;
    logic degen;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  rmq_in_if #(.DATA_WIDTH(DW)) in_ch ();
  rmq_out_if #(.DATA_WIDTH(DW)) out_ch ();

  rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  quat_t expected_quats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit sending_done = 0;

  function automatic fx_t saturate(longint v);
    if (v > QMAX) return fx_t'(QMAX);
    if (v < QMIN) return fx_t'(QMIN);
    return fx_t'(v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint div_by_s(longint n, longint root);
    longint mag, quo;
    mag = (n < 0) ? -n : n;
    quo = ((mag << FB) + root) / (root * 2);
    return (n < 0) ? -quo : quo;
  endfunction

  function automatic quat_t predict_quat(matrix_t a);
    longint m[9];
    longint tr, rad, root, big, qx, qy, qz, qw;
    quat_t r;
    foreach (m[i]) m[i] = longint'(a.m[i]);
    tr = m[0] + m[4] + m[8];
    if (tr > 0) begin
      r.br = rmq_pkg::BR_TRACE;
      rad = tr + ONE;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      r.br = rmq_pkg::BR_X;
      rad = ONE + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      r.br = rmq_pkg::BR_Y;
      rad = ONE + m[4] - m[0] - m[8];
    end else begin
      r.br = rmq_pkg::BR_Z;
      rad = ONE + m[8] - m[0] - m[4];
    end
    if (rad <= 0) begin
      r.x = '0;
      r.y = '0;
      r.z = '0;
      r.w = saturate(ONE);
      r.degen = 1'b1;
      return r;
    end
    root = int_sqrt(rad << FB);
    big = root >> 1;
    case (r.br)
      rmq_pkg::BR_TRACE: begin
        qx = div_by_s(m[5] - m[7], root);
        qy = div_by_s(m[6] - m[2], root);
        qz = div_by_s(m[1] - m[3], root);
        qw = big;
      end
      rmq_pkg::BR_X: begin
        qx = big;
        qy = div_by_s(m[1] + m[3], root);
        qz = div_by_s(m[6] + m[2], root);
        qw = div_by_s(m[5] - m[7], root);
      end
      rmq_pkg::BR_Y: begin
        qx = div_by_s(m[1] + m[3], root);
        qy = big;
        qz = div_by_s(m[5] + m[7], root);
        qw = div_by_s(m[6] - m[2], root);
      end
      default: begin
        qx = div_by_s(m[6] + m[2], root);
        qy = div_by_s(m[5] + m[7], root);
        qz = big;
        qw = div_by_s(m[1] - m[3], root);
      end
    endcase
    r.x = saturate(qx);
    r.y = saturate(qy);
    r.z = saturate(qz);
    r.w = saturate(qw);
    r.degen = 1'b0;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11} = '0;
    {in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
  end

  task automatic send_matrix(matrix_t a);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.m00 <= a.m[0]; in_ch.m01 <= a.m[1]; in_ch.m02 <= a.m[2];
    in_ch.m10 <= a.m[3]; in_ch.m11 <= a.m[4]; in_ch.m12 <= a.m[5];
    in_ch.m20 <= a.m[6]; in_ch.m21 <= a.m[7]; in_ch.m22 <= a.m[8];
    do @(posedge clk); while (!in_ch.ready);
    expected_quats.push_back(predict_quat(a));
  endtask

  // result side
  always begin
    int stall;
    if (!rst_n) begin
      @(posedge clk);
    end else begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    quat_t got, exp_q;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.quat_x; got.y = out_ch.quat_y;
      got.z = out_ch.quat_z; got.w = out_ch.quat_w;
      got.br = out_ch.branch_used; got.degen = out_ch.degenerate;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat x=%0d y=%0d z=%0d w=%0d",
                                       got.x, got.y, got.z, got.w);
      end else begin
        exp_q = expected_quats.pop_front();
        if (got.x !== exp_q.x || got.y !== exp_q.y || got.z !== exp_q.z ||
            got.w !== exp_q.w || got.br !== exp_q.br || got.degen !== exp_q.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %0d br%0d dg%0d got %0d %0d %0d %0d br%0d dg%0d",
                     exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.br, exp_q.degen,
                     got.x, got.y, got.z, got.w, got.br, got.degen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic fx_t rand_fx();
    case ($urandom_range(0, 5))
      0: return fx_t'(QMAX);
      1: return fx_t'(QMIN);
      2: return fx_t'($urandom);
      default: return fx_t'($signed($urandom_range(0, 2 * ONE)) - ONE);
    endcase
  endfunction

  function automatic matrix_t fill_matrix(longint v[9]);
    matrix_t a;
    foreach (a.m[i]) a.m[i] = fx_t'(v[i]);
    return a;
  endfunction

  task automatic test_extremes();
    matrix_t a;
    send_matrix(fill_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
    send_matrix(fill_matrix('{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX}));
    send_matrix(fill_matrix('{QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN}));
    send_matrix(fill_matrix('{QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX}));
    send_matrix(fill_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    foreach (a.m[i]) a.m[i] = fx_t'(QMIN);
    a.m[0] = fx_t'(QMAX);
    send_matrix(a);
  endtask

  task automatic test_branches();
    // rotations by pi about x, y, z and a tie on the diagonal
    send_matrix(fill_matrix('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
    send_matrix(fill_matrix('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}));
    send_matrix(fill_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}));
    send_matrix(fill_matrix('{-ONE, 100, 200, 300, -ONE, 400, 500, 600, -ONE}));
    send_matrix(fill_matrix('{0, ONE, -ONE, ONE, 0, ONE, -ONE, ONE, 0}));
    send_matrix(fill_matrix('{1, 0, 0, 0, 0, 0, 0, 0, -1}));
  endtask

  task automatic test_degenerate();
    // diagonals that avoid the trace branch, and one extreme diagonal that takes it
    send_matrix(fill_matrix('{-ONE, 0, 0, 0, 0, 0, 0, 0, ONE}));
    send_matrix(fill_matrix('{-ONE, 5, 6, 7, ONE - 1, 8, 9, 10, 0}));
    send_matrix(fill_matrix('{0, 0, 0, 0, -ONE - 5, 0, 0, 0, -5}));
    send_matrix(fill_matrix('{QMIN, 1, 2, 3, QMAX, 4, 5, 6, QMAX}));
  endtask

  task automatic test_random(int count);
    matrix_t a;
    real th;
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) begin
        foreach (a.m[i]) a.m[i] = rand_fx();
      end else begin
        // rotation about the x, y or z axis with a small perturbation
        th = ($urandom_range(0, 62831) / 10000.0);
        case ($urandom_range(0, 2))
          0: a = fill_matrix('{ONE, 0, 0, 0, longint'(ONE * $cos(th)),
                               -longint'(ONE * $sin(th)), 0, longint'(ONE * $sin(th)),
                               longint'(ONE * $cos(th))});
          1: a = fill_matrix('{longint'(ONE * $cos(th)), 0, longint'(ONE * $sin(th)), 0,
                               ONE, 0, -longint'(ONE * $sin(th)), 0,
                               longint'(ONE * $cos(th))});
          default: a = fill_matrix('{longint'(ONE * $cos(th)), -longint'(ONE * $sin(th)), 0,
                                     longint'(ONE * $sin(th)), longint'(ONE * $cos(th)),
                                     0, 0, 0, ONE});
        endcase
        foreach (a.m[i]) a.m[i] = a.m[i] + fx_t'($signed($urandom_range(0, 64)) - 32);
      end
      send_matrix(a);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_branches();
    test_degenerate();
    test_random(1300);
    in_ch.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: rotation_matrix_to_quaternion.f
hdl/rmq_pkg.sv
hdl/rmq_in_if.sv
hdl/rmq_out_if.sv
hdl/rotation_matrix_to_quaternion.sv
test/tb_rotation_matrix_to_quaternion.sv
